// ===== rtl/ccr_pkg.sv =====
// ============================================================================
// ccr_pkg
// Shared types, constants, the Pascal row builder and a bit reversal for the combination
// rank / unrank pipeline.
// ============================================================================
package ccr_pkg;

    // Longest bit string the pipeline handles; one step stage per position
    localparam int MAX_BITS = 64;
    localparam int DATA_W   = 64;
    localparam int CNT_W    = $clog2(MAX_BITS + 1);
    localparam int POS_W    = $clog2(MAX_BITS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONES_COUNT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] BIT_COUNT_RST  = CNT_W'(16);
    localparam logic [CNT_W-1:0] ONES_COUNT_RST = CNT_W'(4);

    typedef enum logic {
        ACT_UNRANK = 1'b0,
        ACT_RANK   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_RANK = 2'd1,
        ERR_ONES = 2'd2,
        ERR_MASK = 2'd3
    } t_err;

    // State carried along the step stages
    typedef struct packed {
        t_action             act;
        logic [CNT_W-1:0]    n;    // length in use, saturated
        logic [CNT_W-1:0]    k;    // ones still to place / still ahead
        t_err                err;
        logic [DATA_W-1:0]   acc;  // remaining rank (unrank) or rank sum (rank)
        logic [DATA_W-1:0]   vec;  // built mask (unrank) or aligned mask (rank)
    } t_stage;

    // One finished item
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        t_err              error_code;
    } t_result;

    // One row of the Pascal triangle, C(a, 0..MAX_BITS)
    typedef logic [DATA_W-1:0] t_row [MAX_BITS+1];

    // Builds row a of the Pascal triangle; used on constants only
    function automatic t_row ccr_row(input int a);
        t_row row;
        for (int j = 0; j <= MAX_BITS; j++) begin
            row[j] = '0;
        end
        row[0] = DATA_W'(1);
        for (int i = 1; i <= MAX_BITS; i++) begin
            if (i <= a) begin
                for (int j = MAX_BITS; j >= 1; j--) begin
                    row[j] = row[j] + row[j-1];
                end
            end
        end
        return row;
    endfunction

    // Bit reversal of a data word
    function automatic logic [DATA_W-1:0] ccr_rev(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[DATA_W-1-i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ccr_in_if.sv =====
// ============================================================================
// ccr_in_if
// Input channel: one conversion request per item.
// ============================================================================
interface ccr_in_if
    import ccr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [DATA_W-1:0] operand_value;

    modport source (output valid, output action, output operand_value, input ready);
    modport sink   (input valid, input action, input operand_value, output ready);
endinterface

// ===== rtl/ccr_out_if.sv =====
// ============================================================================
// ccr_out_if
// Output channel: one conversion result per item.
// ============================================================================
interface ccr_out_if
    import ccr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic [1:0]        error_code;

    modport source (output valid, output result_value, output error_code, input ready);
    modport sink   (input valid, input result_value, input error_code, output ready);
endinterface

// ===== rtl/ccr_prep.sv =====
// ============================================================================
// ccr_prep
// Entry stage: length saturation, range checks, popcount and alignment of
// the mask so that step stage a sees bit position n-1-a at index a.
// ============================================================================
module ccr_prep
    import ccr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_action,
    input  logic [DATA_W-1:0] i_operand_value,
    input  logic [CNT_W-1:0]  i_bit_count,
    input  logic [CNT_W-1:0]  i_ones_count,
    output logic              o_valid,
    output t_stage            o_st
);

    logic              r_valid;
    t_stage            r_st;
    t_stage            n_st;
    logic [CNT_W-1:0]  n_len;
    logic [CNT_W-1:0]  sh_amt;
    logic [DATA_W-1:0] hi_mask;
    logic [3:0]        byte_cnt [DATA_W/8];
    logic [CNT_W-1:0]  pop;

    // Length in use, saturated at MAX_BITS
    assign n_len  = (i_bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : i_bit_count;
    assign sh_amt = CNT_W'(MAX_BITS) - n_len;

    // Bits at position n and above (none when n covers the word)
    assign hi_mask = (n_len < CNT_W'(DATA_W)) ? ({DATA_W{1'b1}} << n_len) : '0;

    // Popcount: per-byte counts, then their sum
    always_comb begin
        for (int b = 0; b < DATA_W/8; b++) begin
            byte_cnt[b] = '0;
            for (int i = 0; i < 8; i++) begin
                byte_cnt[b] = byte_cnt[b] + 4'(i_operand_value[b*8+i]);
            end
        end
        pop = '0;
        for (int b = 0; b < DATA_W/8; b++) begin
            pop = pop + CNT_W'(byte_cnt[b]);
        end
    end

    // Initial stage state
    always_comb begin
        n_st.act = t_action'(i_action);
        n_st.n   = n_len;
        if (i_action == ACT_RANK) begin
            n_st.k   = pop;
            n_st.err = ((i_operand_value & hi_mask) != '0) ? ERR_MASK : ERR_OK;
            n_st.acc = '0;
            n_st.vec = ccr_rev(i_operand_value) >> sh_amt;
        end else begin
            n_st.k   = i_ones_count;
            n_st.err = (i_ones_count > n_len) ? ERR_ONES : ERR_OK;
            n_st.acc = i_operand_value;
            n_st.vec = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

// ===== rtl/ccr_step.sv =====
// ============================================================================
// ccr_step
// One bit position of the walk: compare or add against C(a, k-1) and move
// the remaining-ones count. Position a is tied to a constant by the chain.
// ============================================================================
module ccr_step
    import ccr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [POS_W-1:0]  i_a,
    input  logic [DATA_W-1:0] i_term,
    input  logic              i_valid,
    input  t_stage            i_st,
    output logic              o_valid,
    output t_stage            o_st
);

    logic   r_valid;
    t_stage r_st;
    t_stage n_st;
    logic   active;

    // Only positions inside the length in use take part
    assign active = {1'b0, i_a} < i_st.n;

    always_comb begin
        n_st = i_st;
        if (active) begin
            if (i_st.act == ACT_RANK) begin
                // a one uses up a count, a zero adds the skipped block
                if (i_st.vec[i_a]) begin
                    n_st.k = i_st.k - CNT_W'(1);
                end else begin
                    n_st.acc = i_st.acc + i_term;
                end
            end else begin
                // rank falls inside the block with this bit set
                if (i_st.acc < i_term) begin
                    n_st.vec[i_a] = 1'b1;
                    n_st.k        = i_st.k - CNT_W'(1);
                end else begin
                    n_st.acc = i_st.acc - i_term;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

// ===== rtl/ccr_chain.sv =====
// ============================================================================
// ccr_chain
// MAX_BITS step stages in a row, position a running from MAX_BITS-1 down to
// 0, each with its own constant Pascal row for the binomial lookup.
// ============================================================================
module ccr_chain
    import ccr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_stage i_st,
    output logic   o_valid,
    output t_stage o_st
);

    logic   v_link  [MAX_BITS+1];
    t_stage st_link [MAX_BITS+1];

    assign v_link[0]  = i_valid;
    assign st_link[0] = i_st;

    for (genvar s = 0; s < MAX_BITS; s++) begin : g_step
        localparam int   POS = MAX_BITS - 1 - s;
        localparam t_row ROW = ccr_row(POS);

        logic [CNT_W-1:0]  km1;
        logic [DATA_W-1:0] term;

        // C(POS, k-1), zero when k is zero or k-1 exceeds POS
        assign km1  = st_link[s].k - CNT_W'(1);
        assign term = (st_link[s].k == '0 || km1 > CNT_W'(POS)) ? '0 : ROW[km1];

        ccr_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_a     (POS_W'(POS)),
            .i_term  (term),
            .i_valid (v_link[s]),
            .i_st    (st_link[s]),
            .o_valid (v_link[s+1]),
            .o_st    (st_link[s+1])
        );
    end

    assign o_valid = v_link[MAX_BITS];
    assign o_st    = st_link[MAX_BITS];

endmodule

// ===== rtl/ccr_out.sv =====
// ============================================================================
// ccr_out
// Final check and result forming, then a two-entry output queue that lets
// the pipeline keep moving while a result waits to be taken.
// ============================================================================
module ccr_out
    import ccr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_st,
    output logic   o_en,
    ccr_out_if.source o_result
);

    t_result          n_res;
    t_err             err;
    logic [DATA_W-1:0] mask;
    t_result          r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;

    // Unrank is out of range when ones are left over or rank is left over
    always_comb begin
        err = i_st.err;
        if (i_st.act == ACT_UNRANK && err == ERR_OK &&
            (i_st.k != '0 || i_st.acc != '0)) begin
            err = ERR_RANK;
        end
        mask = ccr_rev(i_st.vec) >> (CNT_W'(MAX_BITS) - i_st.n);
        n_res.error_code = err;
        if (err != ERR_OK) begin
            n_res.result_value = '0;
        end else if (i_st.act == ACT_RANK) begin
            n_res.result_value = i_st.acc;
        end else begin
            n_res.result_value = mask;
        end
    end

    // Pipeline advances unless a finished item has nowhere to go
    assign o_en = !i_valid || (r_count != 2'd2);
    assign push = i_valid && (r_count != 2'd2);
    assign pop  = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_res;
        end
    end

    assign o_result.valid        = r_count != 2'd0;
    assign o_result.result_value = r_mem[r_rd_ptr].result_value;
    assign o_result.error_code   = r_mem[r_rd_ptr].error_code;

endmodule

// ===== rtl/combination_rank_unrank_core.sv =====
// Throughput: one item per cycle, stalling while the output queue is full; one register
// stage per bit position (64), plus an entry stage and a two-entry output queue.
// Reset: synchronous, active low; clears valid bits and queue pointers and sets
// bit_count to 16 and ones_count to 4. No clearing pass is needed.
// ============================================================================
// combination_rank_unrank_core
// Rank / unrank between a rank and an n-bit mask in the combinatorial number
// system, LSB-first lexicographic order, with range errors flagged.
// ============================================================================
module combination_rank_unrank_core
    import ccr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    ccr_in_if.sink               i_item,
    ccr_out_if.source            o_result
);

    logic [CNT_W-1:0] r_bit_count;
    logic [CNT_W-1:0] r_ones_count;
    logic             en;
    logic             prep_valid;
    t_stage           prep_st;
    logic             chain_valid;
    t_stage           chain_st;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count  <= BIT_COUNT_RST;
            r_ones_count <= ONES_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIT_COUNT:  r_bit_count  <= i_cfg_data;
                CFG_ONES_COUNT: r_ones_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_item.ready = en;

    ccr_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_item.valid),
        .i_action        (i_item.action),
        .i_operand_value (i_item.operand_value),
        .i_bit_count     (r_bit_count),
        .i_ones_count    (r_ones_count),
        .o_valid         (prep_valid),
        .o_st            (prep_st)
    );

    ccr_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_st    (prep_st),
        .o_valid (chain_valid),
        .o_st    (chain_st)
    );

    ccr_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid),
        .i_st     (chain_st),
        .o_en     (en),
        .o_result (o_result)
    );

endmodule
